FILE: hw/rtl/scf_pkg.sv
// Shared types and constants for the servo command framer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package scf_pkg;

   // command kinds
   localparam logic [2:0] KIND_PARAM    = 3'd0;
   localparam logic [2:0] KIND_SPEED    = 3'd1;
   localparam logic [2:0] KIND_POS7     = 3'd2;
   localparam logic [2:0] KIND_POS8     = 3'd3;
   localparam logic [2:0] KIND_ABSOLUTE = 3'd4;
   localparam logic [2:0] KIND_NEUTRAL  = 3'd5;
   localparam logic [2:0] KIND_SSC      = 3'd6;
   localparam logic [2:0] KIND_LEVEL    = 3'd7;

   // register indexes
   localparam logic [1:0] REG_POS_MIN     = 2'd0;
   localparam logic [1:0] REG_POS_NEUTRAL = 2'd1;
   localparam logic [1:0] REG_POS_MAX     = 2'd2;

   localparam logic [13:0] POS_MIN_RESET     = 14'd500;
   localparam logic [13:0] POS_NEUTRAL_RESET = 14'd3000;
   localparam logic [13:0] POS_MAX_RESET     = 14'd5500;

   // frame bytes
   localparam logic [7:0] SYNC_BYTE     = 8'h80;
   localparam logic [7:0] SSC_SYNC_BYTE = 8'hFF;
   localparam logic [7:0] SSC_RESERVED  = 8'hFF;
   localparam logic [7:0] SSC_SUBST     = 8'hFE;
   localparam logic [13:0] DATA7_MAX    = 14'd127;

   // frame lengths
   localparam logic [2:0] LEN_SHORT = 3'd5;
   localparam logic [2:0] LEN_LONG  = 3'd6;
   localparam logic [2:0] LEN_SSC   = 3'd3;

   // level scaling: x/10000 = (x>>4)/625, and (a*RECIP_625)>>33 is exact
   // for every a below 2^24
   localparam logic signed [14:0] LEVEL_LIMIT = 15'sd10000;
   localparam logic [23:0] RECIP_625   = 24'd13743896;
   localparam int          RECIP_SHIFT = 33;
   localparam logic signed [16:0] POS_HIGH = 17'sd16383;

   // front-to-back queue
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [13:0] pos_min;
      logic [13:0] pos_neutral;
      logic [13:0] pos_max;
   } cfg_type;

   // one fully built frame: byte 0 goes out first
   typedef struct packed {
      logic [5:0][7:0] bytes;
      logic [2:0]      len;
   } frame_type;

endpackage

FILE: hw/rtl/scf_front.sv
// Front end: accepts commands, scales the level of kind 7 in a
// three-stage pipeline and builds the frame bytes. Depends on scf_pkg.
`timescale 1ns / 1ps

module scf_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [2:0]                req_kind,
   input  logic [6:0]                req_controller,
   input  logic [7:0]                req_servo,
   input  logic [13:0]               req_data,
   input  logic signed [14:0]        req_level,
   input  scf_pkg::cfg_type          cfg,
   input  logic [scf_pkg::QCNT_W-1:0] q_count,
   output logic                      q_push,
   output scf_pkg::frame_type        q_frame
);
   import scf_pkg::*;

   logic accept;

   // stage 1
   logic              s1_valid_ff, s1_valid_in;
   logic [2:0]        s1_kind_ff;
   logic [6:0]        s1_ctl_ff;
   logic [7:0]        s1_servo_ff;
   logic [13:0]       s1_data_ff;
   logic [13:0]       s1_zero_ff;
   logic signed [14:0] s1_level_ff, s1_level_in;
   logic signed [14:0] s1_diff_ff, s1_diff_in;

   // stage 2
   logic              s2_valid_ff;
   logic [2:0]        s2_kind_ff;
   logic [6:0]        s2_ctl_ff;
   logic [7:0]        s2_servo_ff;
   logic [13:0]       s2_data_ff;
   logic [13:0]       s2_zero_ff;
   logic signed [29:0] s2_prod_ff, s2_prod_in;

   // stage 3
   logic              s3_valid_ff;
   logic [2:0]        s3_kind_ff;
   logic [6:0]        s3_ctl_ff;
   logic [7:0]        s3_servo_ff;
   logic [13:0]       s3_data_ff;
   logic [13:0]       s3_zero_ff;
   logic              s3_neg_ff, s3_neg_in;
   logic [47:0]       s3_mul_ff, s3_mul_in;

   logic [29:0]       mag;
   logic [23:0]       mag_div16;
   logic [13:0]       quot;
   logic signed [16:0] pos_wide;
   logic [13:0]       pos;
   logic [QCNT_W:0]   inflight_total;
   logic [7:0]        ssc_pos;
   logic [6:0]        lvl_ctl;
   logic [7:0]        slot_byte;
   logic [7:0]        lvl_slot_byte;

   // credit check: queue entries plus beats still in the pipeline
   assign inflight_total = {1'b0, q_count}
                         + (QCNT_W + 1)'(s1_valid_ff)
                         + (QCNT_W + 1)'(s2_valid_ff)
                         + (QCNT_W + 1)'(s3_valid_ff);
   assign busy   = (inflight_total >= (QCNT_W + 1)'(QDEPTH));
   assign accept = start && !busy;
   assign s1_valid_in = accept;

   // clamp level and pick the slope span for its sign
   always_comb begin
      if (req_level < -LEVEL_LIMIT) begin
         s1_level_in = -LEVEL_LIMIT;
      end else if (req_level > LEVEL_LIMIT) begin
         s1_level_in = LEVEL_LIMIT;
      end else begin
         s1_level_in = req_level;
      end
      if (s1_level_in < 0) begin
         s1_diff_in = $signed({1'b0, cfg.pos_neutral}) - $signed({1'b0, cfg.pos_min});
      end else begin
         s1_diff_in = $signed({1'b0, cfg.pos_max}) - $signed({1'b0, cfg.pos_neutral});
      end
   end

   assign s2_prod_in = s1_diff_ff * s1_level_ff;

   // magnitude, shift right by 4, then reciprocal multiply by 1/625
   always_comb begin
      s3_neg_in = s2_prod_ff[29];
      mag       = s3_neg_in ? 30'(-s2_prod_ff) : 30'(s2_prod_ff);
      mag_div16 = mag[27:4];
      s3_mul_in = mag_div16 * RECIP_625;
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      s1_kind_ff  <= req_kind;
      s1_ctl_ff   <= req_controller;
      s1_servo_ff <= req_servo;
      s1_data_ff  <= req_data;
      s1_zero_ff  <= cfg.pos_neutral;
      s1_level_ff <= s1_level_in;
      s1_diff_ff  <= s1_diff_in;

      s2_kind_ff  <= s1_kind_ff;
      s2_ctl_ff   <= s1_ctl_ff;
      s2_servo_ff <= s1_servo_ff;
      s2_data_ff  <= s1_data_ff;
      s2_zero_ff  <= s1_zero_ff;
      s2_prod_ff  <= s2_prod_in;

      s3_kind_ff  <= s2_kind_ff;
      s3_ctl_ff   <= s2_ctl_ff;
      s3_servo_ff <= s2_servo_ff;
      s3_data_ff  <= s2_data_ff;
      s3_zero_ff  <= s2_zero_ff;
      s3_neg_ff   <= s3_neg_in;
      s3_mul_ff   <= s3_mul_in;
   end

   // signed offset from neutral, saturated to the position range
   always_comb begin
      quot     = s3_mul_ff[RECIP_SHIFT+13:RECIP_SHIFT];
      pos_wide = $signed({3'b000, s3_zero_ff})
               + (s3_neg_ff ? -$signed({3'b000, quot}) : $signed({3'b000, quot}));
      if (pos_wide < 0) begin
         pos = 14'd0;
      end else if (pos_wide > POS_HIGH) begin
         pos = POS_HIGH[13:0];
      end else begin
         pos = pos_wide[13:0];
      end
   end

   // frame assembly
   always_comb begin
      lvl_ctl       = {2'b00, s3_servo_ff[7:3]} + 7'd1;
      slot_byte     = s3_servo_ff + {s3_ctl_ff[3:0], 4'b0000};
      lvl_slot_byte = s3_servo_ff + {lvl_ctl[3:0], 4'b0000};
      ssc_pos       = (s3_data_ff[7:0] == SSC_RESERVED) ? SSC_SUBST : s3_data_ff[7:0];
      q_frame       = '0;
      q_push        = s3_valid_ff;
      priority if (s3_kind_ff <= KIND_POS7) begin
         q_frame.len      = LEN_SHORT;
         q_frame.bytes[0] = SYNC_BYTE;
         q_frame.bytes[1] = {1'b0, s3_ctl_ff};
         q_frame.bytes[2] = {5'b00000, s3_kind_ff};
         q_frame.bytes[3] = s3_servo_ff;
         q_frame.bytes[4] = (s3_data_ff > DATA7_MAX) ? DATA7_MAX[7:0] : s3_data_ff[7:0];
      end else if (s3_kind_ff <= KIND_NEUTRAL) begin
         q_frame.len      = LEN_LONG;
         q_frame.bytes[0] = SYNC_BYTE;
         q_frame.bytes[1] = {1'b0, s3_ctl_ff};
         q_frame.bytes[2] = {5'b00000, s3_kind_ff};
         q_frame.bytes[3] = slot_byte;
         q_frame.bytes[4] = {1'b0, s3_data_ff[13:7]};
         q_frame.bytes[5] = {1'b0, s3_data_ff[6:0]};
      end else if (s3_kind_ff == KIND_SSC) begin
         // reserved servo number: the command is dropped
         q_push           = s3_valid_ff && (s3_servo_ff != SSC_RESERVED);
         q_frame.len      = LEN_SSC;
         q_frame.bytes[0] = SSC_SYNC_BYTE;
         q_frame.bytes[1] = s3_servo_ff;
         q_frame.bytes[2] = ssc_pos;
      end else begin
         // scaled level becomes an absolute position frame
         q_frame.len      = LEN_LONG;
         q_frame.bytes[0] = SYNC_BYTE;
         q_frame.bytes[1] = {1'b0, lvl_ctl};
         q_frame.bytes[2] = {5'b00000, KIND_ABSOLUTE};
         q_frame.bytes[3] = lvl_slot_byte;
         q_frame.bytes[4] = {1'b0, pos[13:7]};
         q_frame.bytes[5] = {1'b0, pos[6:0]};
      end
   end

endmodule

FILE: hw/rtl/scf_queue.sv
// Short frame queue between the front end and the byte sender.
// Depends on scf_pkg for the frame type and depth.
`timescale 1ns / 1ps

module scf_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  scf_pkg::frame_type         push_frame,
   input  logic                       pop,
   output scf_pkg::frame_type         head_frame,
   output logic                       empty,
   output logic [scf_pkg::QCNT_W-1:0] count
);
   import scf_pkg::*;

   frame_type          slot_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign head_frame = slot_ff[rd_ptr_ff];
   assign empty      = (count_ff == '0);
   assign count      = count_ff;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

FILE: hw/rtl/scf_back.sv
// Byte sender: takes frames from the queue and puts out one byte beat
// per cycle while it holds a frame, flagging the last byte. Depends on scf_pkg.
`timescale 1ns / 1ps

module scf_back (
   input  logic               clock,
   input  logic               reset,
   input  scf_pkg::frame_type head_frame,
   input  logic               q_empty,
   output logic               q_pop,
   output logic               rsp_valid,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_frame_end
);
   import scf_pkg::*;

   frame_type  cur_ff, cur_in;
   logic [2:0] idx_ff, idx_in;
   logic       active_ff, active_in;
   logic       last;

   assign last          = active_ff && (idx_ff == cur_ff.len - 3'd1);
   assign rsp_valid     = active_ff;
   assign rsp_out_byte  = cur_ff.bytes[idx_ff];
   assign rsp_frame_end = last;

   // next frame loads right behind the last byte of the current one
   always_comb begin
      q_pop     = (!active_ff || last) && !q_empty;
      cur_in    = cur_ff;
      idx_in    = idx_ff;
      active_in = active_ff;
      priority if (q_pop) begin
         cur_in    = head_frame;
         idx_in    = 3'd0;
         active_in = 1'b1;
      end else if (last) begin
         active_in = 1'b0;
      end else if (active_ff) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= 3'd0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
      end
      cur_ff <= cur_in;
   end

endmodule

FILE: hw/rtl/servo_command_framer_top.sv
// Top level of the servo command framer: position registers, front end,
// frame queue and byte sender. Depends on scf_pkg, scf_front, scf_queue, scf_back.
`timescale 1ns / 1ps

// Usage
//   Commands: a command is taken at a rising edge with start high and busy low.
//   The front end accepts one command per cycle while it has queue credit
//   (four frames between queue and pipeline), so busy rises only when the
//   byte sender falls behind.
//   Results: one frame byte per beat on rsp_out_byte, rsp_valid high for one
//   cycle per byte, rsp_frame_end on the last byte. Bytes of a frame follow each
//   other with no gap, and so do successive frames while the next one is queued.
//   Path: a command passes the three pipeline stages for the level scaling
//   and then the frame queue before the first byte of its frame appears.
//   Throughput: set by the byte sender at one byte per cycle while frames are
//   queued, so a command's frame is 5, 6 or 3 bytes long by kind; an SSC command
//   for the reserved servo produces nothing.
//   Registers: csr_index 0 pos_min, 1 pos_neutral, 2 pos_max, csr_ready is
//   always high; write only while no frame is pending.
//   Reset: synchronous; empties pipeline and queue, restores the register
//   defaults 500, 3000 and 5500. The receiver cannot stall the result beats.

module servo_command_framer_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_kind,
   input  logic [6:0]         req_controller,
   input  logic [7:0]         req_servo,
   input  logic [13:0]        req_data,
   input  logic signed [14:0] req_level,
   output logic               rsp_valid,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_frame_end,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [13:0]        csr_data
);
   import scf_pkg::*;

   cfg_type           cfg_ff, cfg_in;
   logic              q_push;
   logic              q_pop;
   logic              q_empty;
   logic [QCNT_W-1:0] q_count;
   frame_type         q_frame;
   frame_type         head_frame;

   assign csr_ready = 1'b1;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_POS_MIN:     cfg_in.pos_min     = csr_data;
            REG_POS_NEUTRAL: cfg_in.pos_neutral = csr_data;
            REG_POS_MAX:     cfg_in.pos_max     = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pos_min     <= POS_MIN_RESET;
         cfg_ff.pos_neutral <= POS_NEUTRAL_RESET;
         cfg_ff.pos_max     <= POS_MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   scf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_controller (req_controller),
      .req_servo      (req_servo),
      .req_data       (req_data),
      .req_level      (req_level),
      .cfg            (cfg_ff),
      .q_count        (q_count),
      .q_push         (q_push),
      .q_frame        (q_frame)
   );

   scf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_frame (q_frame),
      .pop        (q_pop),
      .head_frame (head_frame),
      .empty      (q_empty),
      .count      (q_count)
   );

   scf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_frame    (head_frame),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_frame_end (rsp_frame_end)
   );

`ifndef SYNTHESIS
   // a frame in progress keeps sending beats until its last byte
   a_frame_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_end |=> rsp_valid)
      else $error("frame interrupted before its last byte");

   // credit scheme never lets the queue overflow
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && !q_pop && (q_count == QCNT_W'(QDEPTH))))
      else $error("push into a full frame queue");

   // a full queue must hold off new commands
   a_full_busy: assert property (@(posedge clock) disable iff (reset)
      (q_count == QCNT_W'(QDEPTH)) |-> busy)
      else $error("command accepted with the frame queue full");
`endif

endmodule
